// ===== src/five_register_toy_cpu_execute_macros.svh =====
// ----------------------------------------------------------------------------
// five_register_toy_cpu_execute_macros
// assertion helpers shared by the execute block files
// ----------------------------------------------------------------------------
`ifndef FIVE_REGISTER_TOY_CPU_EXECUTE_MACROS_SVH
`define FIVE_REGISTER_TOY_CPU_EXECUTE_MACROS_SVH

// a condition that holds whenever the antecedent holds, same cycle
`define FRCX_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("frcx: same-cycle check failed");

// a condition that holds in the cycle after the antecedent
`define FRCX_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("frcx: next-cycle check failed");

`endif

// ===== src/frcx_pkg.sv =====
// ----------------------------------------------------------------------------
// frcx_pkg
// shared types, codes and defaults of the toy cpu execute block
// ----------------------------------------------------------------------------
`default_nettype none

package frcx_pkg;

	localparam int NUM_REGS_DEF    = 5;
	localparam int DATA_WIDTH_DEF  = 32;
	localparam int QUEUE_DEPTH_DEF = 2;

	// instruction opcodes as they arrive on the op field
	localparam logic [2:0] OP_MOV = 3'd0;
	localparam logic [2:0] OP_ADD = 3'd1;
	localparam logic [2:0] OP_SUB = 3'd2;
	localparam logic [2:0] OP_PRN = 3'd3;
	localparam logic [2:0] OP_JMP = 3'd4;
	localparam logic [2:0] OP_HLT = 3'd5;

	// instruction class after decode
	typedef enum logic [2:0] {
		CLS_NOP,
		CLS_MOV_REG,
		CLS_MOV_CONST,
		CLS_ADD,
		CLS_SUB,
		CLS_PRN,
		CLS_JMP,
		CLS_HLT
	} cls_t;

	// result kinds
	typedef enum logic [1:0] {
		KIND_PRINT = 2'd0,
		KIND_JUMP  = 2'd1,
		KIND_TRACE = 2'd2,
		KIND_HALT  = 2'd3
	} kind_t;

	// classified instruction, front to back
	typedef struct packed {
		cls_t               cls;
		logic               use_const;
		logic [2:0]         ra;
		logic               ra_ok;
		logic [2:0]         rb;
		logic               rb_ok;
		logic signed [31:0] cval;
		logic [15:0]        target;
		logic               cond;
	} instr_t;

	// one result item
	typedef struct packed {
		kind_t       kind;
		logic [2:0]  idx;
		logic [31:0] value;
		logic [15:0] target;
		logic        last;
	} res_t;

endpackage

`default_nettype wire

// ===== src/frcx_ram.sv =====
// ----------------------------------------------------------------------------
// frcx_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module frcx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 5,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_a,
	output logic      [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

`default_nettype wire

// ===== src/frcx_queue.sv =====
// ----------------------------------------------------------------------------
// frcx_queue
// small fifo between the classifying front and the executing back
// ----------------------------------------------------------------------------
`default_nettype none

module frcx_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] dout,
	output logic                  not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

	logic [WIDTH-1:0] buf_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign dout      = buf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= din;
		end
	end

endmodule

`default_nettype wire

// ===== src/frcx_front.sv =====
// ----------------------------------------------------------------------------
// frcx_front
// takes instruction items and classifies them for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module frcx_front #(
	parameter int NUM_REGS = 5
) (
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         op,
	input  wire logic               use_const,
	input  wire logic [2:0]         reg_first,
	input  wire logic [2:0]         reg_second,
	input  wire logic signed [31:0] imm_value,
	input  wire logic               jump_conditional,
	input  wire logic               q_full,
	output logic                    q_push,
	output frcx_pkg::instr_t        q_item
);

	import frcx_pkg::*;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_item           = '0;
		q_item.use_const = use_const;
		q_item.ra        = reg_first;
		q_item.rb        = reg_second;
		q_item.ra_ok     = (32'(reg_first) < 32'(NUM_REGS));
		q_item.rb_ok     = (32'(reg_second) < 32'(NUM_REGS));
		q_item.cval      = imm_value;
		q_item.cond      = jump_conditional;

		// target line: below one goes to one, above the field saturates
		priority if (imm_value[31] || (imm_value == '0)) begin
			q_item.target = 16'd1;
		end else if (|imm_value[30:16]) begin
			q_item.target = 16'hFFFF;
		end else begin
			q_item.target = imm_value[15:0];
		end

		unique case (op)
			OP_MOV:  q_item.cls = use_const ? CLS_MOV_CONST : CLS_MOV_REG;
			OP_ADD:  q_item.cls = CLS_ADD;
			OP_SUB:  q_item.cls = CLS_SUB;
			OP_PRN:  q_item.cls = CLS_PRN;
			OP_JMP:  q_item.cls = CLS_JMP;
			OP_HLT:  q_item.cls = CLS_HLT;
			default: q_item.cls = CLS_NOP;
		endcase
	end

endmodule

`default_nettype wire

// ===== src/frcx_back.sv =====
// ----------------------------------------------------------------------------
// frcx_back
// executes classified instructions on the register file and emits results
// ----------------------------------------------------------------------------
`default_nettype none
`include "five_register_toy_cpu_execute_macros.svh"

module frcx_back #(
	parameter int NUM_REGS   = 5,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             trace_en,
	input  wire frcx_pkg::instr_t q_item,
	input  wire logic             q_valid,
	output logic                  q_pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output frcx_pkg::res_t        out_res
);

	import frcx_pkg::*;

	localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(NUM_REGS - 1);

	// output register
	logic out_valid_q;
	res_t res_q;
	logic slot_free;

	// dump sequencer
	logic          dump_on_q;
	logic [AW-1:0] dump_idx_q;
	kind_t         dump_kind_q;
	logic          dump_then_q;

	// execute stage
	logic          b_valid_q;
	logic          b_dump_s2;
	kind_t         b_kind_s2;
	logic [AW-1:0] b_idx_s2;
	logic          b_last_s2;
	instr_t        b_instr_s2;

	// register file and read-side fixups
	logic [NUM_REGS-1:0]   valid_q;
	logic                  byp_a_q, byp_b_q, zero_a_q, zero_b_q;
	logic [DATA_WIDTH-1:0] bypd_a_q, bypd_b_q;
	logic [DATA_WIDTH-1:0] ram_a_data, ram_b_data;
	logic [DATA_WIDTH-1:0] rd_a, rd_b;
	logic                  ram_re, we;
	logic [AW-1:0]         waddr, addr_a, addr_b;
	logic [DATA_WIDTH-1:0] wdata;
	logic                  ok_a, ok_b;

	// issue side
	logic          a_go, start_dump, dump_issue;
	kind_t         iss_kind;
	logic [AW-1:0] iss_idx;
	logic          iss_then, iss_end, iss_chain, iss_last;

	// execute side
	logic                  b_fire, b_has, has_dir, acts, needs_dump, is_hlt, taken, we_i;
	logic [AW-1:0]         waddr_i;
	logic [DATA_WIDTH-1:0] wdata_i, cval_d, opb;
	res_t                  res_d;
	kind_t                 start_kind;

	frcx_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(NUM_REGS),
		.AW   (AW)
	) u_regs (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.re     (ram_re),
		.raddr_a(addr_a),
		.raddr_b(addr_b),
		.rdata_a(ram_a_data),
		.rdata_b(ram_b_data)
	);

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	assign rd_a = byp_a_q ? bypd_a_q : (zero_a_q ? '0 : ram_a_data);
	assign rd_b = byp_b_q ? bypd_b_q : (zero_b_q ? '0 : ram_b_data);

	// execute stage
	always_comb begin
		cval_d  = DATA_WIDTH'(b_instr_s2.cval);
		opb     = b_instr_s2.use_const ? cval_d : rd_b;
		taken   = !b_instr_s2.cond || (rd_a == '0);
		is_hlt  = (b_instr_s2.cls == CLS_HLT);
		we_i    = 1'b0;
		waddr_i = AW'(b_instr_s2.ra);
		wdata_i = '0;
		has_dir = 1'b0;
		acts    = 1'b1;
		res_d   = '0;

		unique case (b_instr_s2.cls)
			CLS_MOV_REG: begin
				we_i    = b_instr_s2.rb_ok;
				waddr_i = AW'(b_instr_s2.rb);
				wdata_i = rd_a;
			end
			CLS_MOV_CONST: begin
				we_i    = b_instr_s2.ra_ok;
				wdata_i = cval_d;
			end
			CLS_ADD: begin
				we_i    = b_instr_s2.ra_ok;
				wdata_i = rd_a + opb;
			end
			CLS_SUB: begin
				we_i    = b_instr_s2.ra_ok;
				wdata_i = rd_a - opb;
			end
			CLS_PRN: begin
				has_dir     = 1'b1;
				res_d.kind  = KIND_PRINT;
				res_d.value = b_instr_s2.use_const ? 32'(cval_d) : 32'(rd_a);
			end
			CLS_JMP: begin
				acts         = taken;
				has_dir      = taken;
				res_d.kind   = KIND_JUMP;
				res_d.target = b_instr_s2.target;
			end
			CLS_HLT: begin
			end
			CLS_NOP: begin
				acts = 1'b0;
			end
			default: begin
				acts = 1'b0;
			end
		endcase

		needs_dump = is_hlt || (acts && trace_en);
		start_kind = is_hlt ? KIND_HALT : KIND_TRACE;
		res_d.last = !needs_dump;

		// dump entries carry the register just read
		if (b_dump_s2) begin
			res_d.kind   = b_kind_s2;
			res_d.idx    = 3'(b_idx_s2);
			res_d.value  = 32'(rd_a);
			res_d.target = '0;
			res_d.last   = b_last_s2;
		end

		b_has  = b_dump_s2 || has_dir;
		b_fire = b_valid_q && (!b_has || slot_free);
		we     = b_fire && !b_dump_s2 && we_i;
		waddr  = waddr_i;
		wdata  = wdata_i;
	end

	// issue stage: next dump entry or next queued instruction
	always_comb begin
		a_go       = !b_valid_q || b_fire;
		start_dump = b_fire && !b_dump_s2 && needs_dump;
		dump_issue = start_dump || (a_go && dump_on_q);
		q_pop      = a_go && !dump_issue && q_valid;
		ram_re     = dump_issue || q_pop;

		iss_kind  = start_dump ? start_kind : dump_kind_q;
		iss_idx   = start_dump ? '0 : dump_idx_q;
		iss_then  = start_dump ? (is_hlt && trace_en) : dump_then_q;
		iss_end   = (iss_idx == LAST_IDX);
		iss_chain = (iss_kind == KIND_HALT) && iss_then;
		iss_last  = iss_end && !iss_chain;

		if (dump_issue) begin
			addr_a = iss_idx;
			ok_a   = 1'b1;
			addr_b = iss_idx;
			ok_b   = 1'b0;
		end else begin
			addr_a = AW'(q_item.ra);
			ok_a   = q_item.ra_ok;
			addr_b = AW'(q_item.rb);
			ok_b   = q_item.rb_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			b_valid_q   <= 1'b0;
			dump_on_q   <= 1'b0;
			dump_idx_q  <= '0;
			dump_kind_q <= KIND_TRACE;
			dump_then_q <= 1'b0;
			valid_q     <= '0;
		end else begin
			if (b_fire && b_has) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (a_go) begin
				b_valid_q <= ram_re;
			end
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (dump_issue) begin
				if (iss_end) begin
					// a halt dump with trace on rolls straight into the trace dump
					dump_on_q   <= iss_chain;
					dump_idx_q  <= '0;
					dump_kind_q <= KIND_TRACE;
					dump_then_q <= 1'b0;
				end else begin
					dump_on_q   <= 1'b1;
					dump_idx_q  <= iss_idx + AW'(1);
					dump_kind_q <= iss_kind;
					dump_then_q <= iss_then;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (b_fire && b_has) begin
			res_q <= res_d;
		end
		if (ram_re) begin
			b_dump_s2  <= dump_issue;
			b_kind_s2  <= iss_kind;
			b_idx_s2   <= iss_idx;
			b_last_s2  <= iss_last;
			b_instr_s2 <= q_item;
			// same-cycle write forwarding, unwritten entries read zero
			byp_a_q    <= we && ok_a && (waddr == addr_a);
			byp_b_q    <= we && ok_b && (waddr == addr_b);
			bypd_a_q   <= wdata;
			bypd_b_q   <= wdata;
			zero_a_q   <= !(ok_a && valid_q[addr_a]);
			zero_b_q   <= !(ok_b && valid_q[addr_b]);
		end
	end

	`FRCX_ASSERT_NEXT(chk_dump_starts, clk, arst_n, start_dump, b_valid_q && b_dump_s2 && (b_idx_s2 == '0))
	`FRCX_ASSERT_IMP(chk_last_ends_seq, clk, arst_n, b_valid_q && b_dump_s2 && b_last_s2, !dump_on_q)
	`FRCX_ASSERT_IMP(chk_pop_frees_stage, clk, arst_n, q_pop, !b_valid_q || b_fire)
	`FRCX_ASSERT_IMP(chk_dump_idx, clk, arst_n, dump_on_q, dump_idx_q <= LAST_IDX)

endmodule

`default_nettype wire

// ===== src/five_register_toy_cpu_execute.sv =====
// ----------------------------------------------------------------------------
// five_register_toy_cpu_execute
// execute stage of a small register machine, one decoded instruction per item
// ----------------------------------------------------------------------------
// usage
//  - in channel: one decoded instruction per item (valid/ready)
//  - out channel: result items (print, jump taken, trace or halt dump), last
//    marks the final result of an instruction
//  - cfg channel: single write of trace_enable, always ready, write only while
//    the block is idle
//  - path: the first result of an item passes the queue, the registered
//    read into the execute stage and the output register
//  - throughput: one instruction per cycle while each yields at most one
//    result and out_ready is high; results leave one per cycle; a trace or
//    halt dump is NUM_REGS results (halt with trace 2*NUM_REGS)
//  - the register file is a two-read ram with registered reads; a one-entry
//    execute stage follows the read port
//  - reset: all registers read zero (per-entry valid bits), trace off,
//    queue empty; no clearing pass
//  - a stalled receiver holds the output register; the back end stops and the
//    queue takes up to QUEUE_DEPTH items before in_ready drops
// ----------------------------------------------------------------------------
`default_nettype none

module five_register_toy_cpu_execute #(
	parameter int NUM_REGS    = frcx_pkg::NUM_REGS_DEF,
	parameter int DATA_WIDTH  = frcx_pkg::DATA_WIDTH_DEF,
	parameter int QUEUE_DEPTH = frcx_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_data,
	// instruction items
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         op,
	input  wire logic               use_const,
	input  wire logic [2:0]         reg_first,
	input  wire logic [2:0]         reg_second,
	input  wire logic signed [31:0] imm_value,
	input  wire logic               jump_conditional,
	// result items
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              kind,
	output logic [2:0]              reg_index,
	output logic signed [31:0]      value,
	output logic [15:0]             jump_target,
	output logic                    last
);

	import frcx_pkg::*;

	logic   trace_q;
	logic   q_full, q_push, q_pop, q_valid;
	instr_t f_item, b_item;
	res_t   res;

	// trace enable register, writes always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trace_q <= 1'b0;
		end else if (cfg_valid) begin
			trace_q <= cfg_data;
		end
	end

	// front: accept and classify
	frcx_front #(
		.NUM_REGS(NUM_REGS)
	) u_front (
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.op              (op),
		.use_const       (use_const),
		.reg_first       (reg_first),
		.reg_second      (reg_second),
		.imm_value       (imm_value),
		.jump_conditional(jump_conditional),
		.q_full          (q_full),
		.q_push          (q_push),
		.q_item          (f_item)
	);

	// decoupling queue
	frcx_queue #(
		.WIDTH($bits(instr_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.din      (f_item),
		.full     (q_full),
		.pop      (q_pop),
		.dout     (b_item),
		.not_empty(q_valid)
	);

	// back: register file, execute, result emission
	frcx_back #(
		.NUM_REGS  (NUM_REGS),
		.DATA_WIDTH(DATA_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.trace_en (trace_q),
		.q_item   (b_item),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_res  (res)
	);

	assign kind        = res.kind;
	assign reg_index   = res.idx;
	assign value       = res.value;
	assign jump_target = res.target;
	assign last        = res.last;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the toy cpu execute stage: a scoreboard class keeps
// its own copy of the register file and trace flag, works out the result items
// of every accepted instruction and checks the output stream in order, while
// plain tasks drive bursty instructions, a stalling receiver and trace writes
// ----------------------------------------------------------------------------

import frcx_pkg::*;

// one decoded instruction as driven on the input channel
typedef struct packed {
	logic [2:0]  op;
	logic        use_const;
	logic [2:0]  ra;
	logic [2:0]  rb;
	logic [31:0] cval;
	logic        cond;
} instr_item_t;

class cpu_exec_board;
	logic [31:0] regs [NUM_REGS_DEF];
	bit          trace_on;
	res_t        owed_results [$];
	int          errors;
	int          instr_count;
	int          ignored_count;
	int          results_seen;
	int          kind_count [4];

	function new();
		foreach (regs[i]) regs[i] = '0;
		trace_on = 1'b0;
	endfunction

	function logic [31:0] read_reg(logic [2:0] i);
		return (i < NUM_REGS_DEF) ? regs[i] : '0;
	endfunction

	function void write_reg(logic [2:0] i, logic [31:0] v);
		if (i < NUM_REGS_DEF) regs[i] = v;
	endfunction

	function void owe(kind_t k, logic [2:0] i, logic [31:0] v, logic [15:0] tgt);
		res_t r;
		r.kind   = k;
		r.idx    = i;
		r.value  = v;
		r.target = tgt;
		r.last   = 1'b0;
		owed_results.push_back(r);
	endfunction

	function void dump_regs(kind_t k);
		for (int i = 0; i < NUM_REGS_DEF; i++) owe(k, i[2:0], regs[i], '0);
	endfunction

	// execute one accepted instruction and queue the results it causes
	function void note_instr(instr_item_t it);
		logic [31:0] a;
		logic [31:0] operand;
		logic [15:0] tgt;
		res_t        tail;
		bit          acts;
		int          n;
		acts = 1'b1;
		n = 0;
		a = read_reg(it.ra);
		operand = it.use_const ? it.cval : read_reg(it.rb);
		instr_count++;
		case (it.op)
			OP_MOV: begin
				if (it.use_const) write_reg(it.ra, it.cval);
				else write_reg(it.rb, a);
			end
			OP_ADD: write_reg(it.ra, a + operand);
			OP_SUB: write_reg(it.ra, a - operand);
			OP_PRN: begin
				owe(KIND_PRINT, '0, it.use_const ? it.cval : a, '0);
				n++;
			end
			OP_JMP: begin
				if (it.cond && a != 0) begin
					acts = 1'b0;
				end else begin
					if (it.cval[31] || it.cval == 0) tgt = 16'd1;
					else if (it.cval > 32'h0000_FFFF) tgt = 16'hFFFF;
					else tgt = it.cval[15:0];
					owe(KIND_JUMP, '0, '0, tgt);
					n++;
				end
			end
			OP_HLT: begin
				dump_regs(KIND_HALT);
				n += NUM_REGS_DEF;
			end
			default: begin
				acts = 1'b0;
				ignored_count++;
			end
		endcase
		if (acts && trace_on) begin
			dump_regs(KIND_TRACE);
			n += NUM_REGS_DEF;
		end
		if (n > 0) begin
			tail = owed_results.pop_back();
			tail.last = 1'b1;
			owed_results.push_back(tail);
		end
	endfunction

	task report(input string msg);
		if (errors < 40) $display("mismatch: %s", msg);
		errors++;
	endtask

	task check_result(input logic [1:0] k, input logic [2:0] i, input logic [31:0] v,
			input logic [15:0] tgt, input logic lst);
		res_t want;
		results_seen++;
		if (owed_results.size() == 0) begin
			report($sformatf("result %0d with nothing owed: kind %0d idx %0d value %h",
				results_seen, k, i, v));
			return;
		end
		want = owed_results.pop_front();
		kind_count[want.kind]++;
		if (k !== want.kind)
			report($sformatf("result %0d kind %0d, want %0d", results_seen, k, want.kind));
		if (i !== want.idx)
			report($sformatf("result %0d reg_index %0d, want %0d", results_seen, i, want.idx));
		if (v !== want.value)
			report($sformatf("result %0d value %h, want %h", results_seen, v, want.value));
		if (tgt !== want.target)
			report($sformatf("result %0d jump_target %0d, want %0d", results_seen, tgt,
				want.target));
		if (lst !== want.last)
			report($sformatf("result %0d last %b, want %b", results_seen, lst, want.last));
	endtask
endclass

module testbench;

	localparam logic [2:0] OP_UNUSED_6 = 3'd6;
	localparam logic [2:0] OP_UNUSED_7 = 3'd7;
	localparam int PHASE_ITEMS  = 80;
	localparam int DRAIN_CYCLES = 10;
	localparam int TAIL_CYCLES  = 20;
	localparam int CYCLE_LIMIT  = 400000;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic               cfg_data = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [2:0]         op = '0;
	logic               use_const = 1'b0;
	logic [2:0]         reg_first = '0;
	logic [2:0]         reg_second = '0;
	logic signed [31:0] imm_value = '0;
	logic               jump_conditional = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         kind;
	logic [2:0]         reg_index;
	logic signed [31:0] value;
	logic [15:0]        jump_target;
	logic               last;

	cpu_exec_board board = new();

	// sender burst bookkeeping
	int burst_left = 0;
	// receiver stall pattern
	int rx_mode = 0;
	int rx_tick = 0;
	int stall_left = 0;
	// run statistics
	int cycle_count = 0;
	int cfg_writes = 0;
	bit trace_seen [2];

	five_register_toy_cpu_execute u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.op               (op),
		.use_const        (use_const),
		.reg_first        (reg_first),
		.reg_second       (reg_second),
		.imm_value        (imm_value),
		.jump_conditional (jump_conditional),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.kind             (kind),
		.reg_index        (reg_index),
		.value            (value),
		.jump_target      (jump_target),
		.last             (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog, far above the slowest legal run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycle_count,
				board.owed_results.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// every accepted instruction goes to the predictor at the edge that takes it
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready === 1'b1)
			board.note_instr('{op, use_const, reg_first, reg_second, imm_value,
				jump_conditional});
	end

	// every accepted result item is checked against the oldest owed one
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready)
			board.check_result(kind, reg_index, value, jump_target, last);
	end

	// trace flag writes land in the predictor on the same edge
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready === 1'b1) begin
			board.trace_on = cfg_data;
			trace_seen[cfg_data] = 1'b1;
			cfg_writes++;
		end
	end

	// receiver: the mode is redrawn at random among always ready, random ready,
	// a fixed two-in-three pattern and ready with rare long stalls
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= (rx_tick % 3 != 0);
				default: begin
					out_ready <= 1'b1;
					if ($urandom_range(0, 40) == 0) stall_left = $urandom_range(4, 12);
				end
			endcase
		end
		rx_tick++;
		if (rx_tick % 200 == 0) rx_mode = $urandom_range(0, 3);
	end

	function automatic instr_item_t mk(logic [2:0] o, logic uc, logic [2:0] a, logic [2:0] b,
			logic [31:0] c, logic cnd);
		return '{o, uc, a, b, c, cnd};
	endfunction

	// mostly legal register numbers, now and then a number past the file
	function automatic logic [2:0] rand_reg();
		if ($urandom_range(0, 99) < 8) return 3'($urandom_range(5, 7));
		return 3'($urandom_range(0, NUM_REGS_DEF - 1));
	endfunction

	function automatic logic [31:0] rand_const();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 32'($urandom_range(1, 20));
			2: return -32'($urandom_range(1, 20));
			3: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'hFFFF_FFFF;
					default: return 32'h0001_0000;
				endcase
			end
			4: return 32'($urandom_range(0, 70000));
			default: return $urandom;
		endcase
	endfunction

	function automatic instr_item_t rand_instr();
		instr_item_t it;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 4) it.op = pick[0] ? OP_UNUSED_7 : OP_UNUSED_6;
		else if (pick < 28) it.op = OP_MOV;
		else if (pick < 43) it.op = OP_ADD;
		else if (pick < 58) it.op = OP_SUB;
		else if (pick < 70) it.op = OP_PRN;
		else if (pick < 91) it.op = OP_JMP;
		else it.op = OP_HLT;
		it.use_const = 1'($urandom_range(0, 1));
		it.ra = rand_reg();
		// same register on both sides often zeroes it, which feeds conditional jumps
		it.rb = ($urandom_range(0, 4) == 0) ? it.ra : rand_reg();
		it.cval = rand_const();
		it.cond = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// one instruction item; a new burst starts with a random gap
	task automatic send_item(input instr_item_t it);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(30, 60);
			else burst_left = $urandom_range(1, 10);
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		in_valid         <= 1'b1;
		op               <= it.op;
		use_const        <= it.use_const;
		reg_first        <= it.ra;
		reg_second       <= it.rb;
		imm_value        <= it.cval;
		jump_conditional <= it.cond;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
	endtask

	// hold off the sender until nothing is owed, then let the pipe run empty
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.owed_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_trace(input logic on);
		cfg_valid <= 1'b1;
		cfg_data  <= on;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		instr_item_t it;
		int counted;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part, trace off: wrap, out-of-range registers, jump clamps
		write_trace(1'b0);
		send_item(mk(OP_MOV, 1'b1, 3'd0, 3'd0, 32'h7FFF_FFFF, 1'b0));
		send_item(mk(OP_MOV, 1'b1, 3'd1, 3'd0, 32'h8000_0000, 1'b0));
		send_item(mk(OP_ADD, 1'b0, 3'd0, 3'd1, 32'h0000_1234, 1'b0));
		send_item(mk(OP_ADD, 1'b1, 3'd0, 3'd4, 32'h0000_0001, 1'b0));
		send_item(mk(OP_SUB, 1'b1, 3'd2, 3'd0, 32'h0000_0001, 1'b0));
		send_item(mk(OP_SUB, 1'b0, 3'd3, 3'd1, 32'hFFFF_FFFF, 1'b1));
		send_item(mk(OP_MOV, 1'b0, 3'd1, 3'd4, 32'h0000_0000, 1'b0));
		send_item(mk(OP_PRN, 1'b0, 3'd4, 3'd0, 32'h5555_AAAA, 1'b0));
		send_item(mk(OP_PRN, 1'b1, 3'd0, 3'd7, 32'hFFFF_FFFF, 1'b1));
		// register numbers past the file read zero and drop writes
		send_item(mk(OP_PRN, 1'b0, 3'd7, 3'd7, 32'h1234_5678, 1'b0));
		send_item(mk(OP_MOV, 1'b1, 3'd5, 3'd0, 32'h0000_007B, 1'b0));
		send_item(mk(OP_MOV, 1'b0, 3'd6, 3'd2, 32'h0000_0000, 1'b0));
		send_item(mk(OP_MOV, 1'b0, 3'd1, 3'd7, 32'h0000_0000, 1'b0));
		// jump targets: zero and negative clamp up, large clamps down
		send_item(mk(OP_JMP, 1'b0, 3'd1, 3'd0, 32'h0000_0000, 1'b0));
		send_item(mk(OP_JMP, 1'b1, 3'd1, 3'd0, -32'sd5, 1'b0));
		send_item(mk(OP_JMP, 1'b0, 3'd2, 3'd0, 32'h0001_0000, 1'b0));
		send_item(mk(OP_JMP, 1'b1, 3'd2, 3'd0, 32'h7FFF_FFFF, 1'b0));
		send_item(mk(OP_JMP, 1'b1, 3'd0, 3'd0, 32'h0000_FFFF, 1'b1));
		send_item(mk(OP_JMP, 1'b0, 3'd1, 3'd0, 32'h0000_0064, 1'b1));
		send_item(mk(OP_JMP, 1'b0, 3'd7, 3'd0, 32'h0000_0002, 1'b1));
		send_item(mk(OP_UNUSED_6, 1'b1, 3'd0, 3'd1, 32'hFFFF_FFFF, 1'b1));
		send_item(mk(OP_UNUSED_7, 1'b0, 3'd1, 3'd0, 32'h0000_0001, 1'b0));
		send_item(mk(OP_HLT, 1'b0, 3'd0, 3'd0, 32'h0000_0000, 1'b0));

		// directed part, trace on: every acting op dumps, a skipped jump does not
		settle();
		write_trace(1'b1);
		send_item(mk(OP_ADD, 1'b1, 3'd4, 3'd0, 32'h0000_0010, 1'b0));
		send_item(mk(OP_PRN, 1'b0, 3'd4, 3'd0, 32'h0000_0000, 1'b0));
		send_item(mk(OP_JMP, 1'b0, 3'd4, 3'd0, 32'h0000_0007, 1'b1));
		send_item(mk(OP_JMP, 1'b0, 3'd0, 3'd0, 32'h0000_0009, 1'b1));
		send_item(mk(OP_UNUSED_7, 1'b1, 3'd4, 3'd4, 32'h0000_0000, 1'b1));
		send_item(mk(OP_HLT, 1'b1, 3'd0, 3'd0, 32'h0000_0000, 1'b0));

		// random phases alternate the trace flag; each one pauses once mid-way
		// until the whole backlog has drained
		for (int ph = 0; ph < 4; ph++) begin
			settle();
			write_trace(ph[0]);
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				it = rand_instr();
				send_item(it);
				if (it.op <= OP_HLT) begin
					counted++;
					if (counted == PHASE_ITEMS / 2) settle();
				end
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.owed_results.size() != 0)
			board.report($sformatf("%0d results never arrived", board.owed_results.size()));
		$display("ran %0d instructions (%0d unused opcodes) through %0d trace writes, trace %s",
			board.instr_count, board.ignored_count, cfg_writes,
			(trace_seen[0] && trace_seen[1]) ? "off and on" : "in one setting only");
		$display("checked %0d results: %0d print, %0d jump, %0d trace, %0d halt; %0d errors",
			board.results_seen, board.kind_count[KIND_PRINT], board.kind_count[KIND_JUMP],
			board.kind_count[KIND_TRACE], board.kind_count[KIND_HALT], board.errors);
		if (board.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
